// ===== hw/rtl/gpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the grid path counter.
// Used by every module of the block; depends on nothing else.
package gpc_pkg;

	localparam int MAX_COLS  = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W     = 30;
	localparam int REG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = QPTR_W + 1;

	localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(1000000007);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = CFG_IDX_W'(0),
		REG_GRID_COLS = CFG_IDX_W'(1)
	} gpc_reg_t;

	// one classified cell as it travels from front to back
	typedef struct packed {
		logic             wall;
		logic [COL_W-1:0] col;
		logic             first_row;
		logic             last;
	} gpc_cell_t;

	// zero reads as one, anything above the maximum reads as the maximum
	function automatic logic [REG_W-1:0] clamp_size(logic [REG_W-1:0] v,
			logic [REG_W-1:0] mx);
		logic [REG_W-1:0] r;
		if (v == '0) begin
			r = REG_W'(1);
		end else if (v > mx) begin
			r = mx;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/grid_path_count_mod_top.sv =====
`timescale 1ns / 1ps
// Top level of the grid path counter: front end, cell queue and back end.
// Depends on gpc_pkg, gpc_front, gpc_queue and gpc_back.

// Counts right/down paths through a walled grid modulo 1000000007. Cells
// enter in row-major order, one per item, and each gives one result item
// holding its path count; tlast marks the bottom-right cell, after which a
// new grid begins. The block takes one cell per clock cycle sustained while
// the receiver keeps taking results. When nothing stalls, a cell passes
// through the queue and the stage that holds the registered row store read,
// and the output register then holds its result until the receiver takes
// it. The row store is not cleared after reset and needs no clearing pass:
// the first row of a grid never reads it. Any configuration write restarts
// the grid at the top-left cell. Write configuration only while no items
// are in flight.
module grid_path_count_mod_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// input cells
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [0] is_wall, [7:1] zero
	// result items
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // [29:0] path_count, [31:30] zero
	output logic                          m_axis_tlast,  // last_cell
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpc_pkg::REG_W-1:0]     cfg_data
);

	logic                      q_full;
	logic                      push;
	gpc_pkg::gpc_cell_t        push_cell;
	logic                      pop;
	logic                      q_valid;
	gpc_pkg::gpc_cell_t        q_cell;
	logic [gpc_pkg::CNT_W-1:0] out_count;

	gpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_wall   (s_axis_tdata[0]),
		.q_full    (q_full),
		.push      (push),
		.push_cell (push_cell)
	);

	gpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cell (push_cell),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_cell    (q_cell)
	);

	gpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cell    (q_cell),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_count (out_count),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(32 - gpc_pkg::CNT_W)'(0), out_count};

endmodule

// ===== hw/rtl/gpc_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, grid position tracking and cell
// classification. Depends on gpc_pkg.
module gpc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpc_pkg::REG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_wall,
	input  logic                           q_full,
	output logic                           push,
	output gpc_pkg::gpc_cell_t             push_cell
);

	logic [gpc_pkg::REG_W-1:0] rows_reg_q;
	logic [gpc_pkg::REG_W-1:0] cols_reg_q;
	logic [gpc_pkg::COL_W-1:0] col_q;
	logic [gpc_pkg::ROW_W-1:0] row_q;
	logic [gpc_pkg::REG_W-1:0] rows_eff;
	logic [gpc_pkg::REG_W-1:0] cols_eff;
	logic                      row_end;
	logic                      grid_end;
	logic                      cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// effective grid size
	assign rows_eff = gpc_pkg::clamp_size(rows_reg_q, gpc_pkg::REG_W'(gpc_pkg::MAX_ROWS));
	assign cols_eff = gpc_pkg::clamp_size(cols_reg_q, gpc_pkg::REG_W'(gpc_pkg::MAX_COLS));

	// end of row / end of grid for the cell at the current position
	assign row_end  = (gpc_pkg::REG_W'(col_q) + gpc_pkg::REG_W'(1)) >= cols_eff;
	assign grid_end = row_end
		&& ((gpc_pkg::REG_W'(row_q) + gpc_pkg::REG_W'(1)) >= rows_eff);

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_cell.wall      = in_wall;
		push_cell.col       = col_q;
		push_cell.first_row = (row_q == '0);
		push_cell.last      = grid_end;
	end

	// registers and position; any write restarts the grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg_q <= gpc_pkg::REG_W'(1);
			cols_reg_q <= gpc_pkg::REG_W'(1);
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				gpc_pkg::REG_GRID_ROWS: rows_reg_q <= cfg_data;
				gpc_pkg::REG_GRID_COLS: cols_reg_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= grid_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_cell.last && !cfg_wr) |=> (col_q == '0 && row_q == '0))
		else $error("position did not wrap after the last cell");

endmodule

// ===== hw/rtl/gpc_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified cells between front and back end.
// Depends on gpc_pkg.
module gpc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gpc_pkg::gpc_cell_t push_cell,
	output logic               full,
	input  logic               pop,
	output logic               q_valid,
	output gpc_pkg::gpc_cell_t q_cell
);

	gpc_pkg::gpc_cell_t         store_q [gpc_pkg::QDEPTH];
	logic [gpc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [gpc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [gpc_pkg::QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == gpc_pkg::QCNT_W'(gpc_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_cell  = store_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_cell;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == gpc_pkg::QPTR_W'(gpc_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == gpc_pkg::QPTR_W'(gpc_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gpc_pkg::QCNT_W'(gpc_pkg::QDEPTH))
		else $error("queue fill count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

// ===== hw/rtl/gpc_back.sv =====
`timescale 1ns / 1ps
// Back end: row store, count update with modular reduction and the
// output register. Depends on gpc_pkg.
module gpc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  gpc_pkg::gpc_cell_t          q_cell,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gpc_pkg::CNT_W-1:0]   out_count,
	output logic                        out_last
);

	logic [gpc_pkg::CNT_W-1:0] row_mem [gpc_pkg::MAX_COLS];

	gpc_pkg::gpc_cell_t        cell_s2;
	logic                      valid_s2;
	logic [gpc_pkg::CNT_W-1:0] above_rd_s2;
	logic                      byp_s2;
	logic [gpc_pkg::CNT_W-1:0] byp_cnt_s2;
	logic [gpc_pkg::CNT_W-1:0] left_q;
	logic                      out_valid_q;
	logic [gpc_pkg::CNT_W-1:0] out_count_q;
	logic                      out_last_q;

	logic                      fire;
	logic [gpc_pkg::CNT_W-1:0] above;
	logic [gpc_pkg::CNT_W-1:0] left;
	logic [gpc_pkg::CNT_W:0]   sum;
	logic [gpc_pkg::CNT_W-1:0] count;

	assign fire = valid_s2 && (!out_valid_q || out_ready);
	assign pop  = q_valid && (!valid_s2 || fire);

	// operands: first row seeds the top-left with one, the row above
	// comes from the store or from the write landing on the same edge
	always_comb begin
		if (cell_s2.first_row) begin
			above = (cell_s2.col == '0) ? gpc_pkg::CNT_W'(1) : '0;
		end else if (byp_s2) begin
			above = byp_cnt_s2;
		end else begin
			above = above_rd_s2;
		end
		left = (cell_s2.col == '0) ? '0 : left_q;
	end

	// add and one conditional subtract; a wall gives zero
	always_comb begin
		sum = {1'b0, above} + {1'b0, left};
		if (cell_s2.wall) begin
			count = '0;
		end else if (sum >= {1'b0, gpc_pkg::PATH_MOD}) begin
			count = gpc_pkg::CNT_W'(sum - {1'b0, gpc_pkg::PATH_MOD});
		end else begin
			count = sum[gpc_pkg::CNT_W-1:0];
		end
	end

	// row store: write on completion, registered read on pop
	always_ff @(posedge clk) begin
		if (fire) begin
			row_mem[cell_s2.col] <= count;
		end
		if (pop) begin
			above_rd_s2 <= row_mem[q_cell.col];
		end
	end

	// stage payload, bypass capture, left count and output data
	always_ff @(posedge clk) begin
		if (pop) begin
			cell_s2    <= q_cell;
			byp_s2     <= fire && (cell_s2.col == q_cell.col);
			byp_cnt_s2 <= count;
		end
		if (fire) begin
			left_q      <= count;
			out_count_q <= count;
			out_last_q  <= cell_s2.last;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("completed item not presented at output");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cell_s2.first_row) |-> count < gpc_pkg::PATH_MOD)
		else $error("count out of modular range");

endmodule

// ===== dv/tb_grid_path_count_mod_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for grid_path_count_mod_top: directed cells, then random grids.
// Depends on gpc_pkg and the block's RTL only; expected counts come from a local predictor or the directed rows.
module tb_grid_path_count_mod_top;
	import gpc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;

	// indexes past the register list: they only restart the grid
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	localparam logic CELL_OPEN = 1'b0;
	localparam logic CELL_WALL = 1'b1;

	typedef enum logic {ROW_CFG, ROW_CELL} plan_kind_t;

	typedef struct {
		plan_kind_t           kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [REG_W-1:0]     data;
		bit                   more;   // keep the write channel busy for a following write
		logic                 wall;
		bit                   typed;  // expected result given in the row
		logic [CNT_W-1:0]     count;
		logic                 last;
	} plan_row_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             last;
	} cell_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;   // [0] is_wall, [7:1] zero
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [31:0]          m_axis_tdata;   // [29:0] path_count, [31:30] zero
	logic                 m_axis_tlast;   // last_cell
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	grid_path_count_mod_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predictor state
	logic [CNT_W-1:0] above_counts [MAX_COLS];
	logic [CNT_W-1:0] run_left;
	int               next_col;
	int               next_row;
	logic [REG_W-1:0] rows_reg;
	logic [REG_W-1:0] cols_reg;

	cell_result_t pending_counts [$];
	cell_result_t head;
	plan_row_t    plan [$];

	int fails;
	int cells_sent;
	int results_seen;
	int grids_done;
	int reg_writes;
	int mod_wraps;
	int cycles;
	int send_idle;
	int recv_idle;
	int hold_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random back-pressure, or a long hold-off when asked
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("MISMATCH %s on result %0d: expected %0d, got %0d",
			what, results_seen, want, got);
		fails++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_counts.size() == 0) begin
				report_mismatch("result with nothing pending", -1, m_axis_tdata[CNT_W-1:0]);
			end else begin
				head = pending_counts.pop_front();
				if (m_axis_tdata[CNT_W-1:0] !== head.count)
					report_mismatch("path_count", head.count, m_axis_tdata[CNT_W-1:0]);
				if (m_axis_tlast !== head.last)
					report_mismatch("last_cell", head.last, m_axis_tlast);
			end
			if (m_axis_tlast === 1'b1)
				grids_done++;
			results_seen++;
		end
	end

	// zero reads as one, above the maximum reads as the maximum
	function automatic int effective_size(input logic [REG_W-1:0] v, input int mx);
		int r;
		r = int'(v);
		if (r == 0)
			r = 1;
		else if (r > mx)
			r = mx;
		return r;
	endfunction

	function automatic void restart_grid();
		run_left = '0;
		next_col = 0;
		next_row = 0;
	endfunction

	// path count of the next cell, advancing the position
	function automatic cell_result_t count_next_cell(input logic wall);
		cell_result_t res;
		logic [31:0]  sum;
		logic [CNT_W-1:0] above;
		logic [CNT_W-1:0] left;
		bit row_end;
		if (next_row == 0)
			above = (next_col == 0) ? CNT_W'(1) : '0;
		else
			above = above_counts[next_col];
		left = (next_col == 0) ? '0 : run_left;
		if (wall) begin
			res.count = '0;
		end else begin
			sum = 32'(above) + 32'(left);
			if (sum >= 32'(PATH_MOD)) begin
				sum = sum - 32'(PATH_MOD);
				mod_wraps++;
			end
			res.count = sum[CNT_W-1:0];
		end
		above_counts[next_col] = res.count;
		run_left = res.count;
		row_end = (next_col + 1) >= effective_size(cols_reg, MAX_COLS);
		res.last = row_end && ((next_row + 1) >= effective_size(rows_reg, MAX_ROWS));
		if (row_end) begin
			next_col = 0;
			run_left = '0;
			next_row = res.last ? 0 : next_row + 1;
		end else begin
			next_col++;
		end
		return res;
	endfunction

	// wait until every expected result has come back
	task automatic drain();
		if (pending_counts.size() != 0) begin
			s_axis_tvalid <= 1'b0;
			while (pending_counts.size() != 0)
				@(posedge clk);
		end
	endtask

	// one register write, only with the block idle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data,
			input bit more);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (!more)
			cfg_valid <= 1'b0;
		if (idx == REG_GRID_ROWS)
			rows_reg = data;
		else if (idx == REG_GRID_COLS)
			cols_reg = data;
		restart_grid();
		reg_writes++;
	endtask

	task automatic set_grid(input logic [REG_W-1:0] r, input logic [REG_W-1:0] c);
		cfg_write(REG_GRID_ROWS, r, 1'b1);
		cfg_write(REG_GRID_COLS, c, 1'b0);
	endtask

	// offer one cell; valid stays high after acceptance unless a gap follows
	task automatic put_cell(input logic wall, input bit typed, input logic [CNT_W-1:0] tcount,
			input logic tlast);
		cell_result_t res;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, wall};
		do @(posedge clk); while (!s_axis_tready);
		res = count_next_cell(wall);
		if (typed) begin
			res.count = tcount;
			res.last  = tlast;
		end
		pending_counts.push_back(res);
		cells_sent++;
	endtask

	task automatic feed_cells(input int n, input int wall_pct);
		repeat (n)
			put_cell(($urandom_range(99) < wall_pct) ? CELL_WALL : CELL_OPEN, 1'b0, '0, 1'b0);
	endtask

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [REG_W-1:0] data, input bit more);
		plan_row_t r;
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.data  = data;
		r.more  = more;
		r.wall  = CELL_OPEN;
		r.typed = 1'b0;
		r.count = '0;
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic plan_row_t cell_row(input logic wall, input bit typed,
			input logic [CNT_W-1:0] count, input logic last);
		plan_row_t r;
		r.kind  = ROW_CELL;
		r.idx   = REG_GRID_ROWS;
		r.data  = '0;
		r.more  = 1'b0;
		r.wall  = wall;
		r.typed = typed;
		r.count = count;
		r.last  = last;
		return r;
	endfunction

	// size register value that is out of range or at the maximum
	function automatic logic [REG_W-1:0] odd_size();
		int pick;
		pick = $urandom_range(0, 2);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return REG_W'(MAX_COLS);
		return REG_W'($urandom_range(1025, 2047));
	endfunction

	// random grids under one idling setting
	task automatic run_phase(input int send_pct, input int recv_pct, input int budget,
			input bit big_first, input bit with_hold);
		int stop;
		int pick;
		int r;
		int c;
		int n;
		stop = cells_sent + budget;
		send_idle = send_pct;
		recv_idle = recv_pct;
		// a large, nearly open grid drives the counts well past the modulus
		if (big_first) begin
			r = $urandom_range(18, 19);
			c = $urandom_range(18, 19);
			set_grid(REG_W'(r), REG_W'(c));
			if (with_hold)
				hold_left = HOLD_CYCLES;
			feed_cells(r * c, 2);
		end
		while (cells_sent < stop) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// clamped sizes, grid usually left unfinished
				set_grid(odd_size(), odd_size());
				feed_cells($urandom_range(5, 40), $urandom_range(0, 30));
			end else if (pick == 1) begin
				// restart through an unused index part way into a grid
				feed_cells($urandom_range(1, 10), 20);
				cfg_write(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
					REG_W'($urandom_range(0, 2047)), 1'b0);
				feed_cells($urandom_range(5, 30), 20);
			end else begin
				// whole grids, sometimes with a broken one on the end
				r = $urandom_range(1, 12);
				c = $urandom_range(1, 12);
				set_grid(REG_W'(r), REG_W'(c));
				n = $urandom_range(1, 2) * r * c;
				if ($urandom_range(0, 5) == 0)
					n += $urandom_range(1, r * c);
				feed_cells(n, $urandom_range(0, 40));
			end
		end
		drain();
	endtask

	// stimulus
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_GRID_ROWS;
		cfg_data      = '0;
		fails         = 0;
		cells_sent    = 0;
		results_seen  = 0;
		grids_done    = 0;
		reg_writes    = 0;
		mod_wraps     = 0;
		send_idle     = 16;
		recv_idle     = 81;
		hold_left     = 0;
		rows_reg      = REG_W'(1);
		cols_reg      = REG_W'(1);
		restart_grid();
		foreach (above_counts[i])
			above_counts[i] = '0;

		// after reset the grid is one cell
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd1, 1'b1));
		plan.push_back(cell_row(CELL_WALL, 1'b1, 30'd0, 1'b1));
		// 2 x 3 grid, wall at the end of the first row
		plan.push_back(cfg_row(REG_GRID_ROWS, 11'd2, 1'b1));
		plan.push_back(cfg_row(REG_GRID_COLS, 11'd3, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd1, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd1, 1'b0));
		plan.push_back(cell_row(CELL_WALL, 1'b1, 30'd0, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd1, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd2, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd2, 1'b1));
		// wrapped to a new grid: walled top-left starves its neighbour
		plan.push_back(cell_row(CELL_WALL, 1'b1, 30'd0, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd0, 1'b0));
		// unused indexes restart at the top-left
		plan.push_back(cfg_row(REG_SPARE_A, 11'h555, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd1, 1'b0));
		plan.push_back(cfg_row(REG_SPARE_B, 11'h2AA, 1'b1));
		// zero sizes read as one
		plan.push_back(cfg_row(REG_GRID_ROWS, 11'd0, 1'b1));
		plan.push_back(cfg_row(REG_GRID_COLS, 11'd0, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b1, 30'd1, 1'b1));
		// all-ones sizes read as the maximum
		plan.push_back(cfg_row(REG_GRID_ROWS, 11'h7FF, 1'b1));
		plan.push_back(cfg_row(REG_GRID_COLS, 11'h7FF, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b0, '0, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b0, '0, 1'b0));
		plan.push_back(cell_row(CELL_WALL, 1'b0, '0, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b0, '0, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b0, '0, 1'b0));
		// tallest single-column grid
		plan.push_back(cfg_row(REG_GRID_ROWS, REG_W'(MAX_ROWS), 1'b1));
		plan.push_back(cfg_row(REG_GRID_COLS, 11'd1, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b0, '0, 1'b0));
		plan.push_back(cell_row(CELL_OPEN, 1'b0, '0, 1'b0));
		plan.push_back(cell_row(CELL_WALL, 1'b0, '0, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				cfg_write(plan[i].idx, plan[i].data, plan[i].more);
			else
				put_cell(plan[i].wall, plan[i].typed, plan[i].count, plan[i].last);
		end

		run_phase(16, 81, 380, 1'b1, 1'b0);
		run_phase(81, 16, 360, 1'b0, 1'b0);
		run_phase(0, 0, 380, 1'b1, 1'b1);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d cells and %0d results over %0d finished grids, %0d register writes",
			cells_sent, results_seen, grids_done, reg_writes);
		$display("%0d counts needed the modulus subtract; receiver held off %0d cycles once",
			mod_wraps, HOLD_CYCLES);
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
